// ===== rtl/tpdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tpdp_pkg
// Shared constants, types and helpers of the threshold pruned dot product.
// ----------------------------------------------------------------------------
package tpdp_pkg;

  // Default geometry, handed to the top level parameters
  localparam int LANES_DEF      = 4;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 48;

  // Fixed field widths
  localparam int CNT_W  = 16;  // saturating event counters
  localparam int THR_W  = 31;  // product magnitude threshold, unsigned Q15.16
  localparam int LC_W   = 3;   // lane_count field
  localparam int PADR_W = 3;   // configuration byte address
  localparam int PDAT_W = 32;  // configuration data

  // Configuration register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_ENABLE    = 1'b1
  } reg_idx_e;

  // Per-lane classification handed from a lane to the merge tree
  typedef struct packed {
    logic used;         // lane lies below lane_count
    logic kept;         // product enters the sum
    logic zero_weight;  // weight equals zero
  } lane_flags_t;

  // Number of tree leaves: a power of two, at least two
  function automatic int tree_leaves(input int lanes);
    int n;
    n = 2;
    while (n < lanes) n = n * 2;
    return n;
  endfunction

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Add a small count to a counter, holding at all ones
  function automatic logic [CNT_W-1:0] cnt_sat_add(input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {1'b0, k};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/tpdp_lane.sv =====
// ----------------------------------------------------------------------------
// tpdp_lane
// One multiply lane: registered product of one activation/weight pair and
// its pruning decision against the magnitude threshold.
// ----------------------------------------------------------------------------
module tpdp_lane import tpdp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           advance_i,
  input  logic                           used_i,
  input  logic signed [DATA_WIDTH-1:0]   act_i,
  input  logic signed [DATA_WIDTH-1:0]   weight_i,
  input  logic        [THR_W-1:0]        threshold_i,
  input  logic                           prune_en_i,
  output logic signed [2*DATA_WIDTH-1:0] prod_o,
  output lane_flags_t                    flags_o
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int CMP_W  = max_int(PROD_W, THR_W);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic        [PROD_W-1:0] mag;
  lane_flags_t              flags_d, flags_q;

  // Multiply and classify
  always_comb begin
    prod_d = PROD_W'(act_i) * PROD_W'(weight_i);
    mag    = prod_d[PROD_W-1] ? PROD_W'(-prod_d) : PROD_W'(prod_d);
    flags_d.used        = used_i;
    flags_d.zero_weight = (weight_i == '0);
    flags_d.kept        = !prune_en_i ||
                          ((act_i != '0) && (CMP_W'(mag) > CMP_W'(threshold_i)));
  end

  // Hold the product stage
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q  <= prod_d;
      flags_q <= flags_d;
    end
  end

  assign prod_o  = prod_q;
  assign flags_o = flags_q;

endmodule

// ===== rtl/tpdp_merge.sv =====
// ----------------------------------------------------------------------------
// tpdp_merge
// Registered merge tree over the lanes. Each lane is a saturating add,
// x -> clamp(x + p, lo, hi); two such steps compose into one of the same
// form, so the tree folds all lanes of an item into one offset and one pair
// of clamp bounds, in lane order, plus the per-item event counts.
// ----------------------------------------------------------------------------
module tpdp_merge import tpdp_pkg::*; #(
  parameter int LANES      = LANES_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  localparam int PROD_W    = 2 * DATA_WIDTH,
  localparam int NPOW      = tree_leaves(LANES),
  localparam int LEVELS    = $clog2(NPOW),
  localparam int SUM_W     = PROD_W + LEVELS,
  localparam int CW        = $clog2(NPOW + 1),
  localparam int NODE_W    = SUM_W + 2 * ACC_WIDTH + 3 * CW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     in_valid_i,
  input  logic                     in_last_i,
  input  logic signed [PROD_W-1:0] prod_i  [LANES],
  input  lane_flags_t              flags_i [LANES],
  output logic [NODE_W-1:0]        root_o,
  output logic                     root_valid_o,
  output logic                     root_last_o
);

  localparam int EXT_W = max_int(ACC_WIDTH, SUM_W) + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [SUM_W-1:0]     s;
    logic signed [ACC_WIDTH-1:0] lo;
    logic signed [ACC_WIDTH-1:0] hi;
    logic        [CW-1:0]        pairs;
    logic        [CW-1:0]        zw;
    logic        [CW-1:0]        sp;
  } node_t;

  function automatic logic signed [ACC_WIDTH-1:0] clamp(
      input logic signed [EXT_W-1:0]     v,
      input logic signed [ACC_WIDTH-1:0] lo,
      input logic signed [ACC_WIDTH-1:0] hi);
    logic signed [ACC_WIDTH-1:0] r;
    if (v < EXT_W'(lo))      r = lo;
    else if (v > EXT_W'(hi)) r = hi;
    else                     r = ACC_WIDTH'(v);
    return r;
  endfunction

  // Apply f first, then g
  function automatic node_t compose(input node_t f, input node_t g);
    node_t r;
    r.s     = SUM_W'(f.s + g.s);
    r.lo    = clamp(EXT_W'(f.lo) + EXT_W'(g.s), g.lo, g.hi);
    r.hi    = clamp(EXT_W'(f.hi) + EXT_W'(g.s), g.lo, g.hi);
    r.pairs = CW'(f.pairs + g.pairs);
    r.zw    = CW'(f.zw + g.zw);
    r.sp    = CW'(f.sp + g.sp);
    return r;
  endfunction

  node_t leaf   [NPOW];
  node_t node_q [NPOW-1];
  logic [LEVELS-1:0] vld_q, lst_q;

  // Turn each lane into a leaf step; padding leaves pass the sum through
  for (genvar i = 0; i < NPOW; i++) begin : g_leaf
    if (i < LANES) begin : g_lane
      logic skip;
      assign skip = flags_i[i].used && !flags_i[i].kept;
      assign leaf[i].s     = (flags_i[i].used && flags_i[i].kept) ?
                             SUM_W'(prod_i[i]) : '0;
      assign leaf[i].lo    = ACC_LO;
      assign leaf[i].hi    = ACC_HI;
      assign leaf[i].pairs = CW'(flags_i[i].used);
      assign leaf[i].zw    = CW'(skip && flags_i[i].zero_weight);
      assign leaf[i].sp    = CW'(skip && !flags_i[i].zero_weight);
    end else begin : g_pad
      assign leaf[i] = '{s: '0, lo: ACC_LO, hi: ACC_HI, pairs: '0, zw: '0, sp: '0};
    end
  end

  // Fold sibling pairs, one register per tree level
  for (genvar k = 0; k < NPOW - 1; k++) begin : g_node
    node_t left, right;
    if (2 * k + 1 >= NPOW - 1) begin : g_from_leaf
      assign left  = leaf[2 * k + 1 - (NPOW - 1)];
      assign right = leaf[2 * k + 2 - (NPOW - 1)];
    end else begin : g_from_node
      assign left  = node_q[2 * k + 1];
      assign right = node_q[2 * k + 2];
    end
    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        node_q[k] <= compose(left, right);
      end
    end
  end

  // Advance item valid and last marks alongside the tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      lst_q <= '0;
    end else if (advance_i) begin
      for (int j = LEVELS - 1; j > 0; j--) begin
        vld_q[j] <= vld_q[j-1];
        lst_q[j] <= lst_q[j-1];
      end
      vld_q[0] <= in_valid_i;
      lst_q[0] <= in_last_i;
    end
  end

  assign root_o       = node_q[0];
  assign root_valid_o = vld_q[LEVELS-1];
  assign root_last_o  = lst_q[LEVELS-1];

endmodule

// ===== rtl/threshold_pruned_dot_product.sv =====
// ----------------------------------------------------------------------------
// threshold_pruned_dot_product
// Streaming multiply-accumulate with runtime threshold pruning.
// ----------------------------------------------------------------------------
// Each input transfer carries up to LANES activation/weight pairs (signed
// Q8.8); the block takes one transfer per clock unless stalled. Every pair
// has its own multiplier lane, a registered merge tree folds the lanes of a
// transfer into one saturating step, and a single accumulator applies that
// step, so the accumulator loop (one wide add and clamp) sets the rate. A
// transfer with tlast set yields one result transfer through the lane
// registers, the tree levels and the output register. The input stalls
// only when a finished result is still waiting at the output and the next
// one is ready to leave the tree. With pruning enabled a pair enters the
// sum only when its activation is nonzero and |act * weight| exceeds the
// threshold; skipped pairs are counted as zero-weight or small-product.
// ----------------------------------------------------------------------------
module threshold_pruned_dot_product import tpdp_pkg::*; #(
  parameter int LANES      = LANES_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  localparam int IN_W      = ((2 * LANES * DATA_WIDTH + LC_W + 7) / 8) * 8,
  localparam int OUT_W     = ((ACC_WIDTH + 3 * CNT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // act_0..act_{LANES-1}, weight_0..weight_{LANES-1}, lane_count
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              s_axis_tlast,   // last
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // dot_sum, zero_weight_pruned, small_product_pruned, pair_total
  output logic [OUT_W-1:0]  m_axis_tdata,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PADR_W-1:0] paddr,
  input  logic [PDAT_W-1:0] pwdata,
  output logic [PDAT_W-1:0] prdata,
  output logic              pready
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int NPOW   = tree_leaves(LANES);
  localparam int LEVELS = $clog2(NPOW);
  localparam int SUM_W  = PROD_W + LEVELS;
  localparam int CW     = $clog2(NPOW + 1);
  localparam int NODE_W = SUM_W + 2 * ACC_WIDTH + 3 * CW;
  localparam int EXT_W  = max_int(ACC_WIDTH, SUM_W) + 1;

  typedef struct packed {
    logic signed [SUM_W-1:0]     s;
    logic signed [ACC_WIDTH-1:0] lo;
    logic signed [ACC_WIDTH-1:0] hi;
    logic        [CW-1:0]        pairs;
    logic        [CW-1:0]        zw;
    logic        [CW-1:0]        sp;
  } node_t;

  // Configuration registers
  logic [THR_W-1:0] thr_q;
  logic             en_q;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      en_q  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_THRESHOLD: thr_q <= pwdata[THR_W-1:0];
        REG_ENABLE:    en_q  <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = PDAT_W'(thr_q);
      REG_ENABLE:    prdata = PDAT_W'(en_q);
      default:       prdata = '0;
    endcase
  end

  // Pipeline control: stall only when a result is blocked at the output
  logic  advance;
  logic  root_v, root_last;
  logic  out_valid_q;
  node_t root;
  logic  in_xfer;

  assign advance       = !(root_v && root_last && out_valid_q && !m_axis_tready);
  assign s_axis_tready = advance;
  assign in_xfer       = s_axis_tvalid && advance;

  // Lane stage
  logic [LC_W-1:0]          lane_count;
  logic signed [PROD_W-1:0] prod  [LANES];
  lane_flags_t              flags [LANES];
  logic                     v0_q, last0_q;

  assign lane_count = s_axis_tdata[2 * LANES * DATA_WIDTH +: LC_W];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tpdp_lane #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_lane (
      .clk_i       (clk_i),
      .advance_i   (advance),
      .used_i      (lane_count > i),
      .act_i       (s_axis_tdata[i * DATA_WIDTH +: DATA_WIDTH]),
      .weight_i    (s_axis_tdata[(LANES + i) * DATA_WIDTH +: DATA_WIDTH]),
      .threshold_i (thr_q),
      .prune_en_i  (en_q),
      .prod_o      (prod[i]),
      .flags_o     (flags[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      last0_q <= 1'b0;
    end else if (advance) begin
      v0_q    <= in_xfer;
      last0_q <= s_axis_tlast;
    end
  end

  // Merge tree
  logic [NODE_W-1:0] root_bits;

  tpdp_merge #(
    .LANES      (LANES),
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .in_valid_i   (v0_q),
    .in_last_i    (last0_q),
    .prod_i       (prod),
    .flags_i      (flags),
    .root_o       (root_bits),
    .root_valid_o (root_v),
    .root_last_o  (root_last)
  );

  assign root = node_t'(root_bits);

  // Accumulate: one add, then clamp to the item's folded bounds
  logic signed [ACC_WIDTH-1:0] sum_q, sum_d;
  logic        [CNT_W-1:0]     zw_q, sp_q, pair_q, zw_d, sp_d, pair_d;
  logic signed [EXT_W-1:0]     sum_ext;

  always_comb begin
    sum_ext = EXT_W'(sum_q) + EXT_W'(root.s);
    if (sum_ext < EXT_W'(root.lo))      sum_d = root.lo;
    else if (sum_ext > EXT_W'(root.hi)) sum_d = root.hi;
    else                                sum_d = ACC_WIDTH'(sum_ext);
    zw_d   = cnt_sat_add(zw_q,   CNT_W'(root.zw));
    sp_d   = cnt_sat_add(sp_q,   CNT_W'(root.sp));
    pair_d = cnt_sat_add(pair_q, CNT_W'(root.pairs));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      zw_q   <= '0;
      sp_q   <= '0;
      pair_q <= '0;
    end else if (advance && root_v) begin
      if (root_last) begin
        sum_q  <= '0;
        zw_q   <= '0;
        sp_q   <= '0;
        pair_q <= '0;
      end else begin
        sum_q  <= sum_d;
        zw_q   <= zw_d;
        sp_q   <= sp_d;
        pair_q <= pair_d;
      end
    end
  end

  // Output register: load on a finished dot product, drop once transferred
  logic signed [ACC_WIDTH-1:0] out_sum_q;
  logic        [CNT_W-1:0]     out_zw_q, out_sp_q, out_pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && root_v && root_last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && root_v && root_last) begin
      out_sum_q  <= sum_d;
      out_zw_q   <= zw_d;
      out_sp_q   <= sp_d;
      out_pair_q <= pair_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_pair_q, out_sp_q, out_zw_q, out_sum_q});

  // Checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && root_v && root_last |=> (sum_q == '0) && (pair_q == '0) &&
                                       (zw_q == '0) && (sp_q == '0))
    else $error("running state not cleared after a finished dot product");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && root_v && root_last))
    else $error("result raised without a finished dot product");

  a_skips_within_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_pair_q != {CNT_W{1'b1}}) |->
      ({1'b0, out_pair_q} >= ({1'b0, out_zw_q} + {1'b0, out_sp_q})))
    else $error("pruned pairs exceed pairs seen");

endmodule
